FILE: design/stft_pkg.sv
// Package for the STFT spectrogram engine: sizes, codes, control/status
// structs and the twiddle table. No dependencies.
`default_nettype none
package stft_pkg;

    localparam int DFT_POINTS = 64;
    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int TW_STRIDE  = 64 / DFT_POINTS;
    localparam int NUM_BINS   = DFT_POINTS / 2 + 1;
    localparam int LEN_W      = $clog2(DFT_POINTS) + 1;
    localparam int IDX_W      = $clog2(DFT_POINTS);
    localparam int K_W        = $clog2(NUM_BINS);
    localparam int ACC_W      = 40;
    localparam int OUT_W      = 23;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_WINDOW = 1'b1;

    localparam logic [1:0] REG_FRAME_LENGTH  = 2'd0;
    localparam logic [1:0] REG_HOP           = 2'd1;
    localparam logic [1:0] REG_WINDOW_ENABLE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } ctl_state_t;

    typedef struct packed {
        logic             issue;
        logic [IDX_W-1:0] i;
        logic [K_W-1:0]   k;
        logic             clear_acc;
        logic             load_out;
        logic             last;
    } ctl_cmd_t;

    typedef struct packed {
        logic             frame_go;
        logic             pipe_empty;
        logic             out_busy;
        logic [LEN_W-1:0] len;
    } dp_status_t;

    function automatic logic signed [15:0] quarter_cos(input logic [4:0] m);
        logic signed [15:0] r;
        unique case (m)
            5'd0:  r = 16'sd32767;
            5'd1:  r = 16'sd32609;
            5'd2:  r = 16'sd32137;
            5'd3:  r = 16'sd31356;
            5'd4:  r = 16'sd30273;
            5'd5:  r = 16'sd28898;
            5'd6:  r = 16'sd27245;
            5'd7:  r = 16'sd25329;
            5'd8:  r = 16'sd23170;
            5'd9:  r = 16'sd20787;
            5'd10: r = 16'sd18204;
            5'd11: r = 16'sd15446;
            5'd12: r = 16'sd12539;
            5'd13: r = 16'sd9512;
            5'd14: r = 16'sd6393;
            5'd15: r = 16'sd3212;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] cos_tw(input logic [5:0] m);
        logic signed [15:0] r;
        if (m <= 6'd16)
            r = quarter_cos(m[4:0]);
        else if (m <= 6'd32)
            r = -quarter_cos(5'(6'd32 - m));
        else if (m <= 6'd48)
            r = -quarter_cos(5'(m - 6'd32));
        else
            r = quarter_cos(5'(7'd64 - {1'b0, m}));
        return r;
    endfunction

    function automatic logic signed [15:0] sin_tw(input logic [5:0] m);
        return cos_tw(6'(m + 6'd48));
    endfunction

endpackage
`default_nettype wire

FILE: design/stft_if.sv
// Streaming channel interfaces (input items and result items).
// No dependencies.
`default_nettype none
interface stft_in_if;
    logic                valid;
    logic                ready;
    logic                command;
    logic signed [15:0]  sample;
    logic                new_signal;
    logic [5:0]          coeff_index;
    logic signed [15:0]  coeff_value;
    modport source (output valid, command, sample, new_signal, coeff_index, coeff_value,
                    input ready);
    modport sink (input valid, command, sample, new_signal, coeff_index, coeff_value,
                  output ready);
endinterface

interface stft_out_if;
    logic                valid;
    logic                ready;
    logic [15:0]         frame_index;
    logic [5:0]          bin_index;
    logic signed [22:0]  real_part;
    logic signed [22:0]  imag_part;
    logic                last_bin;
    modport source (output valid, frame_index, bin_index, real_part, imag_part, last_bin,
                    input ready);
    modport sink (input valid, frame_index, bin_index, real_part, imag_part, last_bin,
                  output ready);
endinterface
`default_nettype wire

FILE: design/stft_ctrl.sv
// Sequencer: walks sample index i and bin k for each frame.
// Depends on stft_pkg.
`default_nettype none
module stft_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire stft_pkg::dp_status_t status,
    output stft_pkg::ctl_cmd_t       cmd,
    output logic                     in_ready
);
    import stft_pkg::*;

    ctl_state_t       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [K_W-1:0]   k_reg, k_next;

    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        cmd.issue     = 1'b0;
        cmd.i         = i_reg;
        cmd.k         = k_reg;
        cmd.clear_acc = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.last      = (k_reg == K_W'(NUM_BINS - 1));
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !status.frame_go;
                if (status.frame_go)
                begin
                    cmd.clear_acc = 1'b1;
                    i_next        = '0;
                    k_next        = '0;
                    state_next    = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if ({1'b0, i_reg} == status.len - LEN_W'(1))
                    state_next = ST_DRAIN;
                else
                    i_next = i_reg + IDX_W'(1);
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty && !status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    if (cmd.last)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.clear_acc = 1'b1;
                        k_next        = k_reg + K_W'(1);
                        i_next        = '0;
                        state_next    = ST_RUN;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/stft_dp.sv
// Datapath: framing counters, sample ring and window memories, windowing
// and complex MAC pipeline, result register. Depends on stft_pkg.
`default_nettype none
module stft_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_accept,
    input  wire logic                 command,
    input  wire logic signed [15:0]   sample,
    input  wire logic                 new_signal,
    input  wire logic [5:0]           coeff_index,
    input  wire logic signed [15:0]   coeff_value,
    input  wire logic [6:0]           frame_length,
    input  wire logic [7:0]           hop,
    input  wire logic                 window_enable,
    input  wire stft_pkg::ctl_cmd_t   cmd,
    output stft_pkg::dp_status_t      status,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [15:0]               frame_index,
    output logic [5:0]                bin_index,
    output logic signed [22:0]        real_part,
    output logic signed [22:0]        imag_part,
    output logic                      last_bin
);
    import stft_pkg::*;

    logic signed [15:0] ring_mem [RING_DEPTH];
    logic signed [15:0] win_mem  [RING_DEPTH];

    logic [RING_AW-1:0] ptr_reg;
    logic [6:0]         seen_reg;
    logic [7:0]         hc_reg;
    logic [15:0]        fc_reg;
    logic [RING_AW-1:0] start_reg;
    logic               go_reg;

    logic [LEN_W-1:0]   len_eff;
    logic [7:0]         hop_eff;
    logic [6:0]         seen_base, seen_n;
    logic [7:0]         hc_base, hc_n;
    logic [RING_AW-1:0] ptr_n;
    logic               trig;

    always_comb
    begin
        if (frame_length == 7'd0)
            len_eff = LEN_W'(1);
        else if (frame_length > 7'(DFT_POINTS))
            len_eff = LEN_W'(DFT_POINTS);
        else
            len_eff = LEN_W'(frame_length);
        hop_eff   = (hop == 8'd0) ? 8'd1 : hop;
        seen_base = new_signal ? 7'd0 : seen_reg;
        hc_base   = new_signal ? 8'd0 : hc_reg;
        seen_n    = (seen_base < 7'd127) ? seen_base + 7'd1 : seen_base;
        hc_n      = (hc_base != 8'd0) ? hc_base - 8'd1 : hc_base;
        ptr_n     = ptr_reg + RING_AW'(1);
        trig      = ({1'b0, seen_n} >= 8'(len_eff)) && (hc_n == 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            seen_reg <= '0;
            hc_reg   <= '0;
            fc_reg   <= '0;
            go_reg   <= 1'b0;
        end
        else
        begin
            go_reg <= 1'b0;
            if (in_accept && command == CMD_SAMPLE)
            begin
                ptr_reg  <= ptr_n;
                seen_reg <= seen_n;
                hc_reg   <= trig ? hop_eff : hc_n;
                go_reg   <= trig;
                if (new_signal)
                    fc_reg <= '0;
            end
            else if (cmd.load_out && cmd.last)
                fc_reg <= fc_reg + 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && command == CMD_SAMPLE && trig)
            start_reg <= ptr_n - RING_AW'(len_eff);
    end

    // memories: one write, one registered read
    logic signed [15:0] ring_q, win_q;
    logic [RING_AW-1:0] ring_addr;
    assign ring_addr = start_reg + RING_AW'(cmd.i);

    always_ff @(posedge clk)
    begin
        if (in_accept && command == CMD_SAMPLE)
            ring_mem[ptr_reg] <= sample;
        if (in_accept && command == CMD_WINDOW)
            win_mem[coeff_index] <= coeff_value;
        if (cmd.issue)
        begin
            ring_q <= ring_mem[ring_addr];
            win_q  <= win_mem[RING_AW'(cmd.i)];
        end
    end

    // MAC pipeline: read -> window product -> round/twiddle -> products -> accumulate
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic [5:0]         m1_reg, m2_reg;
    logic signed [31:0] wprod_reg;
    logic signed [15:0] raw2_reg;
    logic signed [16:0] x3_reg;
    logic signed [15:0] cos3_reg, sin3_reg;
    logic signed [32:0] pre_reg, pim_reg;
    logic signed [ACC_W-1:0] acc_re_reg, acc_im_reg;
    logic [5:0]         m_idx;
    logic signed [32:0] wrnd;
    logic signed [16:0] x_win;

    assign m_idx = 6'(int'(cmd.k) * int'(cmd.i) * TW_STRIDE);

    always_comb
    begin
        wrnd = (33'(wprod_reg) + 33'sd16384) >>> 15;
        if (wrnd > 33'sd32767)
            x_win = 17'sd32767;
        else if (wrnd < -33'sd32768)
            x_win = -17'sd32768;
        else
            x_win = 17'(wrnd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg    <= m_idx;
        m2_reg    <= m1_reg;
        wprod_reg <= ring_q * win_q;
        raw2_reg  <= ring_q;
        x3_reg    <= window_enable ? x_win : 17'(raw2_reg);
        cos3_reg  <= cos_tw(m2_reg);
        sin3_reg  <= sin_tw(m2_reg);
        pre_reg   <= x3_reg * cos3_reg;
        pim_reg   <= x3_reg * sin3_reg;
        if (cmd.clear_acc)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else if (v4_reg)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(pre_reg);
            acc_im_reg <= acc_im_reg - ACC_W'(pim_reg);
        end
    end

    // result register
    logic signed [ACC_W-1:0] rre, rim;
    logic signed [OUT_W-1:0] sre, sim;
    logic                    ov_reg;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > ACC_W'(4194303))
            r = OUT_W'(4194303);
        else if (v < -ACC_W'(4194304))
            r = OUT_W'(-4194304);
        else
            r = OUT_W'(v);
        return r;
    endfunction

    always_comb
    begin
        rre = (acc_re_reg + ACC_W'(16384)) >>> 15;
        rim = (acc_im_reg + ACC_W'(16384)) >>> 15;
        sre = sat_out(rre);
        sim = sat_out(rim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.load_out)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            frame_index <= fc_reg;
            bin_index   <= 6'(cmd.k);
            real_part   <= sre;
            imag_part   <= sim;
            last_bin    <= cmd.last;
        end
    end

    assign out_valid         = ov_reg;
    assign status.frame_go   = go_reg;
    assign status.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign status.out_busy   = ov_reg;
    assign status.len        = len_eff;

endmodule
`default_nettype wire

FILE: design/stft_spectrogram_engine.sv
// STFT spectrogram engine top level: APB config registers, sequencer and
// datapath. Depends on stft_pkg, stft_if, stft_ctrl, stft_dp.
//
// Samples (command 0) and window writes (command 1) arrive on in_ch. A sample
// that completes a frame starts a direct DFT of the latest frame_length samples,
// windowed when window_enable is set, and DFT_POINTS/2+1 bins leave on out_ch,
// bin 0 first, last_bin on the final one. One shared complex multiply-
// accumulate unit takes one sample per cycle, and each bin waits for the
// pipeline to drain and for the result register to be free; in_ch is not
// ready while a frame is in progress. Results are bit exact with single final
// rounding per bin.
`default_nettype none
module stft_spectrogram_engine (
    input  wire logic         clk,
    input  wire logic         rst_n,
    stft_in_if.sink           in_ch,
    stft_out_if.source        out_ch,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import stft_pkg::*;

    logic [6:0] frame_length_reg;
    logic [7:0] hop_reg;
    logic       window_enable_reg;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg  <= 7'd64;
            hop_reg           <= 8'd32;
            window_enable_reg <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_FRAME_LENGTH:  frame_length_reg  <= pwdata[6:0];
                REG_HOP:           hop_reg           <= pwdata[7:0];
                REG_WINDOW_ENABLE: window_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_LENGTH:  prdata = {25'd0, frame_length_reg};
            REG_HOP:           prdata = {24'd0, hop_reg};
            REG_WINDOW_ENABLE: prdata = {31'd0, window_enable_reg};
            default:           prdata = 32'd0;
        endcase
    end

    ctl_cmd_t   cmd;
    dp_status_t status;
    logic       in_ready;

    assign in_ch.ready = in_ready;

    stft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    stft_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_accept     (in_ch.valid && in_ready),
        .command       (in_ch.command),
        .sample        (in_ch.sample),
        .new_signal    (in_ch.new_signal),
        .coeff_index   (in_ch.coeff_index),
        .coeff_value   (in_ch.coeff_value),
        .frame_length  (frame_length_reg),
        .hop           (hop_reg),
        .window_enable (window_enable_reg),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .frame_index   (out_ch.frame_index),
        .bin_index     (out_ch.bin_index),
        .real_part     (out_ch.real_part),
        .imag_part     (out_ch.imag_part),
        .last_bin      (out_ch.last_bin)
    );

endmodule
`default_nettype wire

FILE: design/stft_checker.sv
// Port-level checks for the STFT spectrogram engine, bound to the top level.
// Depends on stft_pkg.
`default_nettype none
module stft_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       in_command,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [5:0] bin_index,
    input wire logic       last_bin
);
    import stft_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_last_bin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_bin |-> bin_index == 6'(NUM_BINS - 1))
        else $error("last_bin on wrong bin");

    a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_bin |=> !in_ready)
        else $error("input taken in the middle of a frame");

    a_win_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_command == CMD_WINDOW |=> !$rose(out_valid))
        else $error("result after window write");

endmodule

bind stft_spectrogram_engine stft_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .bin_index  (out_ch.bin_index),
    .last_bin   (out_ch.last_bin)
);
`default_nettype wire

FILE: verif/tb.sv
// Testbench for stft_spectrogram_engine: drives samples and window writes, predicts
// every bin of every frame and checks them in order. Depends on stft_pkg, stft_if.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stft_pkg::*;

    typedef struct packed {
        logic [15:0] frame_index;
        logic [5:0]  bin_index;
        logic [22:0] real_part;
        logic [22:0] imag_part;
        logic        last_bin;
    } bin_rec_t;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // round half up by 2^15
    function automatic longint rnd15(longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    class spectrum_board;
        int qcos[17] = '{32767, 32609, 32137, 31356, 30273, 28898, 27245, 25329, 23170,
                         20787, 18204, 15446, 12539, 9512, 6393, 3212, 0};
        shortint ring[64];
        shortint wtab[64];
        int ptr, seen, countdown, fcount;
        int flen, hop, wen;
        bin_rec_t bins_due[$];
        int mismatches;

        function new();
            foreach (ring[i]) ring[i] = 0;
            foreach (wtab[i]) wtab[i] = 0;
            ptr = 0; seen = 0; countdown = 0; fcount = 0;
            flen = 64; hop = 32; wen = 0;
            mismatches = 0;
        endfunction

        function int twc(int m);
            m = m & 63;
            if (m <= 16) return qcos[m];
            if (m <= 32) return -qcos[32 - m];
            if (m <= 48) return -qcos[m - 32];
            return qcos[64 - m];
        endfunction

        function void set_reg(logic [1:0] idx, int v);
            if (idx == REG_FRAME_LENGTH) flen = v & 8'h7f;
            else if (idx == REG_HOP) hop = v & 8'hff;
            else if (idx == REG_WINDOW_ENABLE) wen = v & 1;
        endfunction

        function void note(logic cmd, shortint s, logic ns, logic [5:0] ci, shortint cv);
            int len, start;
            longint x[64];
            longint re, im;
            bin_rec_t b;
            if (cmd == CMD_WINDOW) begin
                wtab[ci] = cv;
                return;
            end
            if (ns) begin
                seen = 0; countdown = 0; fcount = 0;
            end
            ring[ptr] = s;
            ptr = (ptr + 1) & 63;
            if (seen < 127) seen++;
            if (countdown > 0) countdown--;
            len = flen;
            if (len == 0) len = 1;
            if (len > 64) len = 64;
            if (seen < len || countdown != 0) return;
            countdown = hop;
            start = (ptr + 64 - len) & 63;
            for (int i = 0; i < 64; i++) begin
                x[i] = 0;
                if (i < len) begin
                    x[i] = ring[(start + i) & 63];
                    if (wen) x[i] = clip(rnd15(x[i] * wtab[i]), -32768, 32767);
                end
            end
            for (int k = 0; k < 33; k++) begin
                re = 0; im = 0;
                for (int i = 0; i < 64; i++) begin
                    re += x[i] * twc(k * i);
                    im -= x[i] * twc(((k * i) & 63) + 48);
                end
                b.frame_index = fcount[15:0];
                b.bin_index = k[5:0];
                b.real_part = 23'(clip(rnd15(re), -4194304, 4194303));
                b.imag_part = 23'(clip(rnd15(im), -4194304, 4194303));
                b.last_bin = (k == 32);
                bins_due.push_back(b);
            end
            fcount = (fcount + 1) & 16'hffff;
        endfunction

        function void check(bin_rec_t got);
            bin_rec_t want;
            if (bins_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected bin: frame %0d bin %0d", got.frame_index,
                             got.bin_index);
                return;
            end
            want = bins_due.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("bin mismatch: exp f%0d b%0d re %0d im %0d l%0d, ",
                             want.frame_index, want.bin_index, $signed(want.real_part),
                             $signed(want.imag_part), want.last_bin,
                             "got f%0d b%0d re %0d im %0d l%0d", got.frame_index,
                             got.bin_index, $signed(got.real_part), $signed(got.imag_part),
                             got.last_bin);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    bit quiet;
    int rx_stall;
    longint cycles;

    stft_in_if in_ch ();
    stft_out_if out_ch ();

    spectrum_board sb = new();

    stft_spectrogram_engine dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (rx_stall > 0)
        begin
            out_ch.ready <= 1'b0;
            rx_stall--;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_ch.ready <= 1'b0;
            rx_stall = $urandom_range(1, 5) - 1;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        bin_rec_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.frame_index = out_ch.frame_index;
            got.bin_index = out_ch.bin_index;
            got.real_part = out_ch.real_part;
            got.imag_part = out_ch.imag_part;
            got.last_bin = out_ch.last_bin;
            sb.check(got);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, int v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic push_item(logic cmd, shortint s, logic ns, logic [5:0] ci, shortint cv);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd; in_ch.sample <= s; in_ch.new_signal <= ns;
        in_ch.coeff_index <= ci; in_ch.coeff_value <= cv;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note(cmd, s, ns, ci, cv);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.bins_due.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic configure(int len, int hp, int we);
        drain();
        write_reg(REG_FRAME_LENGTH, len);
        write_reg(REG_HOP, hp);
        write_reg(REG_WINDOW_ENABLE, we);
    endtask

    task automatic random_items(int n, int pause_at);
        int r;
        shortint s;
        for (int j = 0; j < n; j++)
        begin
            if (j == pause_at) drain();
            r = $urandom_range(0, 99);
            s = shortint'($urandom);
            if ($urandom_range(0, 7) == 0) s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            if (r < 10)
                push_item(CMD_WINDOW, shortint'($urandom), 1'($urandom),
                          6'($urandom), shortint'($urandom));
            else
                push_item(CMD_SAMPLE, s, r < 14, 6'($urandom), shortint'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_ch.valid = 0; in_ch.command = 0; in_ch.sample = 0; in_ch.new_signal = 0;
        in_ch.coeff_index = 0; in_ch.coeff_value = 0;
        out_ch.ready = 0;
        quiet = 0; rx_stall = 0; cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole window table first; extremes at the front
        for (int i = 0; i < 64; i++)
            push_item(CMD_WINDOW, 0, 1'b0, 6'(i),
                      i == 0 ? 16'sh8000 : (i == 1 ? 16'sh7fff : shortint'($urandom)));

        configure(1, 1, 1);
        push_item(CMD_SAMPLE, 16'sh8000, 1'b1, 0, 0);   // saturates through window
        push_item(CMD_SAMPLE, 16'sh7fff, 1'b0, 0, 0);
        push_item(CMD_SAMPLE, 0, 1'b0, 0, 0);
        configure(4, 2, 0);
        push_item(CMD_SAMPLE, 16'sh7fff, 1'b1, 0, 0);
        push_item(CMD_SAMPLE, 16'sh7fff, 1'b0, 0, 0);
        push_item(CMD_SAMPLE, 16'sh7fff, 1'b0, 0, 0);
        push_item(CMD_SAMPLE, 16'sh7fff, 1'b0, 0, 0);
        push_item(CMD_WINDOW, 16'sh1234, 1'b1, 6'd63, 16'sh7fff);
        push_item(CMD_SAMPLE, 16'sh8000, 1'b0, 0, 0);
        push_item(CMD_SAMPLE, 16'sh8000, 1'b0, 0, 0);
        push_item(CMD_SAMPLE, -1, 1'b0, 0, 0);

        configure(64, 32, 0);
        random_items(20, -1);
        configure(1, 1, 1);
        random_items(20, -1);
        configure(8, 3, 1);
        random_items(30, 15);
        configure(0, 0, 0);          // zero length and zero hop act as 1
        random_items(20, -1);
        configure(127, 255, 1);      // length above the DFT size clamps
        random_items(30, -1);
        configure(16, 5, 1);
        random_items(35, -1);
        configure(33, 7, 0);
        random_items(30, -1);
        configure(12, 4, 1);
        quiet = 1;
        random_items(50, -1);
        drain();

        if (sb.mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
design/stft_pkg.sv
design/stft_if.sv
design/stft_ctrl.sv
design/stft_dp.sv
design/stft_spectrogram_engine.sv
design/stft_checker.sv
verif/tb.sv
